// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/dtfs_pkg.sv -----
package dtfs_pkg;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINSEC_W = 6;
    localparam int ACT_W    = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [YEAR_W-1:0]   MIN_YEAR_RST = 12'd1970;
    localparam logic [YEAR_W-1:0]   MAX_YEAR_RST = 12'd2100;
    localparam logic [MONTH_W-1:0]  MONTH_TOP    = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_TOP     = 5'd23;
    localparam logic [MINSEC_W-1:0] MINSEC_TOP   = 6'd59;

    // ceil(2^16 / 25): low 16 bits of y * 2622 stay below 2622 exactly
    // when y is a multiple of 25, for any 12-bit y
    localparam logic [YEAR_W-1:0] DIV25_MUL = 12'd2622;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD     = 4'd0,
        ACT_DAY_UP   = 4'd1,
        ACT_DAY_DN   = 4'd2,
        ACT_MONTH_UP = 4'd3,
        ACT_MONTH_DN = 4'd4,
        ACT_YEAR_UP  = 4'd5,
        ACT_YEAR_DN  = 4'd6,
        ACT_HOUR_UP  = 4'd7,
        ACT_HOUR_DN  = 4'd8,
        ACT_MIN_UP   = 4'd9,
        ACT_MIN_DN   = 4'd10,
        ACT_SEC_UP   = 4'd11,
        ACT_SEC_DN   = 4'd12,
        ACT_APPLY    = 4'd13
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_YEAR = 1'd0,
        REG_MAX_YEAR = 1'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [YEAR_W-1:0]   load_year;
        logic [MONTH_W-1:0]  load_month;
        logic [DAY_W-1:0]    load_day;
        logic [HOUR_W-1:0]   load_hour;
        logic [MINSEC_W-1:0] load_minute;
        logic [MINSEC_W-1:0] load_second;
    } t_req;

    typedef struct packed {
        logic [YEAR_W-1:0]   cur_year;
        logic [MONTH_W-1:0]  cur_month;
        logic [DAY_W-1:0]    cur_day;
        logic [HOUR_W-1:0]   cur_hour;
        logic [MINSEC_W-1:0] cur_minute;
        logic [MINSEC_W-1:0] cur_second;
        logic                applied;
    } t_rsp;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINSEC_W-1:0] minute;
        logic [MINSEC_W-1:0] second;
    } t_dt;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, DIV25_MUL};
        div25 = prod[15:0] < {4'd0, DIV25_MUL};
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/core/date_time_field_stepper.sv -----
// Date and time setter: holds year, month, day, hour, minute and second.
// Request channel (i_in_valid / o_in_stall / i_in_data) carries one action:
// load all fields, step one field up or down with wrap, or apply.
// Result channel (o_out_valid / i_out_stall / o_out_data) returns every
// field after the action, with applied set only for apply.
// The result is registered: it is valid in the cycle after its request is accepted.
// Throughput: one request per cycle; the result register is the only
// stage, so a request is taken whenever the result is empty or leaving.
// Month length (with the Gregorian leap rule) and the day clamp are
// computed in the same cycle as the field step.
// When the receiver stalls, the result holds and o_in_stall rises until
// the result is taken.
// Year bounds are written through i_cfg_we / i_cfg_idx / i_cfg_data (index 0 min
// year, 1 max year); the user must write them only while the block is idle, which the block does not enforce.
// Reset (synchronous, active low) sets 1970-01-01 00:00:00, bounds
// 1970..2100, and empties the result register.
module date_time_field_stepper (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dtfs_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dtfs_pkg::t_rsp                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [dtfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [dtfs_pkg::YEAR_W-1:0]      i_cfg_data
);
    import dtfs_pkg::*;

    `include "assert_macros.svh"

    t_dt               r_dt;
    t_dt               n_dt;
    logic              r_applied;
    logic              n_applied;
    logic              r_out_valid;
    logic [YEAR_W-1:0] r_min_year;
    logic [YEAR_W-1:0] r_max_year;
    logic              in_acc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    dtfs_step u_step (
        .i_cur      (r_dt),
        .i_req      (i_in_data),
        .i_min_year (r_min_year),
        .i_max_year (r_max_year),
        .o_nxt      (n_dt),
        .o_applied  (n_applied)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt.year   <= MIN_YEAR_RST;
            r_dt.month  <= 4'd1;
            r_dt.day    <= 5'd1;
            r_dt.hour   <= 5'd0;
            r_dt.minute <= 6'd0;
            r_dt.second <= 6'd0;
            r_applied   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_dt      <= n_dt;
                r_applied <= n_applied;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= MIN_YEAR_RST;
            r_max_year <= MAX_YEAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_YEAR: r_min_year <= i_cfg_data;
                REG_MAX_YEAR: r_max_year <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data.cur_year   = r_dt.year;
    assign o_out_data.cur_month  = r_dt.month;
    assign o_out_data.cur_day    = r_dt.day;
    assign o_out_data.cur_hour   = r_dt.hour;
    assign o_out_data.cur_minute = r_dt.minute;
    assign o_out_data.cur_second = r_dt.second;
    assign o_out_data.applied    = r_applied;

    `ASSERT_RST(a_apply_flag, i_clk, i_rst_n, in_acc && (i_in_data.action == ACT_APPLY) |=> o_out_valid && o_out_data.applied, "apply request did not raise applied")

    `ASSERT_RST(a_day_step, i_clk, i_rst_n, in_acc && (i_in_data.action == ACT_DAY_UP) && (r_dt.day < 5'd28) && (r_dt.day != 5'd0) |=> r_dt.day == $past(r_dt.day) + 5'd1, "day step up lost its increment")

    `ASSERT_RST(a_out_drain, i_clk, i_rst_n, o_out_valid && !i_out_stall && !i_in_valid |=> !o_out_valid, "result left valid after it was taken")

    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

// ----- rtl/core/dtfs_step.sv -----
module dtfs_step (
    input  dtfs_pkg::t_dt                      i_cur,
    input  dtfs_pkg::t_req                     i_req,
    input  logic [dtfs_pkg::YEAR_W-1:0]        i_min_year,
    input  logic [dtfs_pkg::YEAR_W-1:0]        i_max_year,
    output dtfs_pkg::t_dt                      o_nxt,
    output logic                               o_applied
);
    import dtfs_pkg::*;

    logic [YEAR_W-1:0]  nxt_year;
    logic [MONTH_W-1:0] nxt_month;
    logic               clamp;
    logic [DAY_W-1:0]   len;

    // year and month first; the month length follows from them
    always_comb begin
        nxt_year  = i_cur.year;
        nxt_month = i_cur.month;
        clamp     = 1'b0;
        case (i_req.action)
            ACT_LOAD: begin
                nxt_year  = i_req.load_year;
                nxt_month = i_req.load_month;
            end
            ACT_MONTH_UP: begin
                nxt_month = (i_cur.month >= MONTH_TOP) ? 4'd1 : i_cur.month + 4'd1;
                clamp     = 1'b1;
            end
            ACT_MONTH_DN: begin
                nxt_month = (i_cur.month <= 4'd1 || i_cur.month > MONTH_TOP)
                            ? MONTH_TOP : i_cur.month - 4'd1;
                clamp     = 1'b1;
            end
            ACT_YEAR_UP: begin
                nxt_year = (i_cur.year >= i_max_year || i_cur.year < i_min_year)
                           ? i_min_year : i_cur.year + 12'd1;
                clamp    = 1'b1;
            end
            ACT_YEAR_DN: begin
                nxt_year = (i_cur.year <= i_min_year || i_cur.year > i_max_year)
                           ? i_max_year : i_cur.year - 12'd1;
                clamp    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign len = month_len(nxt_month, is_leap(nxt_year));

    always_comb begin
        o_nxt       = i_cur;
        o_nxt.year  = nxt_year;
        o_nxt.month = nxt_month;
        o_applied   = 1'b0;
        case (i_req.action)
            ACT_LOAD: begin
                o_nxt.day    = i_req.load_day;
                o_nxt.hour   = i_req.load_hour;
                o_nxt.minute = i_req.load_minute;
                o_nxt.second = i_req.load_second;
            end
            ACT_DAY_UP: begin
                o_nxt.day = (i_cur.day >= len) ? 5'd1 : i_cur.day + 5'd1;
            end
            ACT_DAY_DN: begin
                o_nxt.day = (i_cur.day <= 5'd1) ? len : i_cur.day - 5'd1;
            end
            ACT_HOUR_UP: begin
                o_nxt.hour = (i_cur.hour >= HOUR_TOP) ? 5'd0 : i_cur.hour + 5'd1;
            end
            ACT_HOUR_DN: begin
                o_nxt.hour = (i_cur.hour == 5'd0 || i_cur.hour > HOUR_TOP)
                             ? HOUR_TOP : i_cur.hour - 5'd1;
            end
            ACT_MIN_UP: begin
                o_nxt.minute = (i_cur.minute >= MINSEC_TOP) ? 6'd0 : i_cur.minute + 6'd1;
            end
            ACT_MIN_DN: begin
                o_nxt.minute = (i_cur.minute == 6'd0 || i_cur.minute > MINSEC_TOP)
                               ? MINSEC_TOP : i_cur.minute - 6'd1;
            end
            ACT_SEC_UP: begin
                o_nxt.second = (i_cur.second >= MINSEC_TOP) ? 6'd0 : i_cur.second + 6'd1;
            end
            ACT_SEC_DN: begin
                o_nxt.second = (i_cur.second == 6'd0 || i_cur.second > MINSEC_TOP)
                               ? MINSEC_TOP : i_cur.second - 6'd1;
            end
            ACT_APPLY: begin
                o_applied = 1'b1;
            end
            default: begin
            end
        endcase
        // clamp day to the new month length
        if (clamp && (i_cur.day > len)) begin
            o_nxt.day = len;
        end
    end

endmodule

// ----- tb/tb.sv -----
module tb;
    import dtfs_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_A = 4'd14;
    localparam logic [ACT_W-1:0] ACT_SPARE_B = 4'd15;
    localparam int NUM_PHASES     = 10;
    localparam int REQS_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    class date_time_scoreboard;
        logic [YEAR_W-1:0]   min_year;
        logic [YEAR_W-1:0]   max_year;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINSEC_W-1:0] minute;
        logic [MINSEC_W-1:0] second;
        t_rsp                pending_rsp_q[$];
        int unsigned         errors;
        int unsigned         requests;
        int unsigned         checked;

        function new();
            min_year = MIN_YEAR_RST;
            max_year = MAX_YEAR_RST;
            year     = 12'd1970;
            month    = 4'd1;
            day      = 5'd1;
            hour     = '0;
            minute   = '0;
            second   = '0;
            errors   = 0;
            requests = 0;
            checked  = 0;
        endfunction

        function void set_bounds(logic [YEAR_W-1:0] lo, logic [YEAR_W-1:0] hi);
            min_year = lo;
            max_year = hi;
        endfunction

        function int unsigned pending();
            return pending_rsp_q.size();
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned month_days(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
            if (m == 4'd2)
                return leap_year(y) ? 29 : 28;
            if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
                return 30;
            return 31;
        endfunction

        function void clamp_day();
            int unsigned len;
            len = month_days(month, year);
            if (day > len)
                day = DAY_W'(len);
        endfunction

        function void note_request(t_req r);
            int unsigned len;
            logic        applied_flag;
            t_rsp        want;
            applied_flag = 1'b0;
            len = month_days(month, year);
            requests++;
            case (r.action)
                ACT_LOAD: begin
                    year   = r.load_year;
                    month  = r.load_month;
                    day    = r.load_day;
                    hour   = r.load_hour;
                    minute = r.load_minute;
                    second = r.load_second;
                end
                ACT_DAY_UP: day = (day >= len) ? 5'd1 : day + 5'd1;
                ACT_DAY_DN: day = (day <= 1) ? DAY_W'(len) : day - 5'd1;
                ACT_MONTH_UP: begin
                    month = (month >= MONTH_TOP) ? 4'd1 : month + 4'd1;
                    clamp_day();
                end
                ACT_MONTH_DN: begin
                    month = (month <= 1 || month > MONTH_TOP) ? MONTH_TOP : month - 4'd1;
                    clamp_day();
                end
                ACT_YEAR_UP: begin
                    year = (year >= max_year || year < min_year) ? min_year : year + 12'd1;
                    clamp_day();
                end
                ACT_YEAR_DN: begin
                    year = (year <= min_year || year > max_year) ? max_year : year - 12'd1;
                    clamp_day();
                end
                ACT_HOUR_UP: hour = (hour >= HOUR_TOP) ? 5'd0 : hour + 5'd1;
                ACT_HOUR_DN: hour = (hour == 0 || hour > HOUR_TOP) ? HOUR_TOP : hour - 5'd1;
                ACT_MIN_UP: minute = (minute >= MINSEC_TOP) ? 6'd0 : minute + 6'd1;
                ACT_MIN_DN: begin
                    minute = (minute == 0 || minute > MINSEC_TOP) ? MINSEC_TOP : minute - 6'd1;
                end
                ACT_SEC_UP: second = (second >= MINSEC_TOP) ? 6'd0 : second + 6'd1;
                ACT_SEC_DN: begin
                    second = (second == 0 || second > MINSEC_TOP) ? MINSEC_TOP : second - 6'd1;
                end
                ACT_APPLY: applied_flag = 1'b1;
                default: ;
            endcase
            want.cur_year   = year;
            want.cur_month  = month;
            want.cur_day    = day;
            want.cur_hour   = hour;
            want.cur_minute = minute;
            want.cur_second = second;
            want.applied    = applied_flag;
            pending_rsp_q.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("MISMATCH: %s", msg);
        endtask

        task compare_field(string name, logic [YEAR_W-1:0] got_v, logic [YEAR_W-1:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                          checked, name, got_v, want_v));
        endtask

        task check_result(t_rsp got);
            t_rsp want;
            if (pending_rsp_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no request pending", got));
                return;
            end
            want = pending_rsp_q.pop_front();
            compare_field("year", got.cur_year, want.cur_year);
            compare_field("month", got.cur_month, want.cur_month);
            compare_field("day", got.cur_day, want.cur_day);
            compare_field("hour", got.cur_hour, want.cur_hour);
            compare_field("minute", got.cur_minute, want.cur_minute);
            compare_field("second", got.cur_second, want.cur_second);
            compare_field("applied", got.applied, want.applied);
            checked++;
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_req                 i_in_data   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [YEAR_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_rsp                 o_out_data;

    date_time_scoreboard sb;
    int unsigned         cycle_cnt    = 0;
    int unsigned         stuck_cycles = 0;
    int unsigned         notable_years[11] = '{0, 4, 100, 400, 1900, 1996, 2000, 2024,
                                               2100, 4000, 4095};

    date_time_field_stepper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_data);
            case ((cycle_cnt / 97) % 4)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                2:       i_out_stall <= ((cycle_cnt % 7) < 3);
                default: i_out_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", stuck_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // hold the request until it is taken
    task automatic send_req(input t_req r);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_action(input logic [ACT_W-1:0] act);
        t_req        r;
        logic [63:0] noise;
        noise    = {$urandom, $urandom};
        r        = noise[$bits(t_req)-1:0];
        r.action = act;
        send_req(r);
    endtask

    task automatic send_load(input int unsigned y, m, d, h, mi, s);
        t_req r;
        r.action      = ACT_LOAD;
        r.load_year   = YEAR_W'(y);
        r.load_month  = MONTH_W'(m);
        r.load_day    = DAY_W'(d);
        r.load_hour   = HOUR_W'(h);
        r.load_minute = MINSEC_W'(mi);
        r.load_second = MINSEC_W'(s);
        send_req(r);
    endtask

    task automatic idle_sender(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_bounds(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MIN_YEAR;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_YEAR;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_bounds(lo, hi);
    endtask

    // mostly field steps on in-range dates, some raw loads and spare codes
    function automatic t_req random_req(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        t_req        r;
        logic [63:0] noise;
        int unsigned pick;
        noise = {$urandom, $urandom};
        r     = noise[$bits(t_req)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 3) begin
            r.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
        end else if (pick < 14) begin
            r.action = ACT_LOAD;
            if ($urandom_range(0, 9) != 0) begin
                case ($urandom_range(0, 3))
                    0:       r.load_year = lo + YEAR_W'($urandom_range(0, 2));
                    1:       r.load_year = hi - YEAR_W'($urandom_range(0, 2));
                    2:       r.load_year = YEAR_W'(notable_years[$urandom_range(0, 10)]);
                    default: r.load_year = YEAR_W'($urandom_range(0, 4095));
                endcase
                r.load_month  = MONTH_W'($urandom_range(1, 12));
                r.load_day    = DAY_W'($urandom_range(0, 1) ? $urandom_range(27, 31)
                                                            : $urandom_range(1, 31));
                r.load_hour   = HOUR_W'($urandom_range(0, 23));
                r.load_minute = MINSEC_W'($urandom_range(0, 59));
                r.load_second = MINSEC_W'($urandom_range(0, 59));
            end
        end else begin
            r.action = ACT_W'($urandom_range(ACT_DAY_UP, ACT_APPLY));
        end
        return r;
    endfunction

    task automatic random_traffic(input int unsigned count);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_req(random_req(sb.min_year, sb.max_year));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    task automatic directed_checks();
        send_action(ACT_APPLY);
        send_load(2024, 2, 29, 23, 59, 59);
        send_action(ACT_DAY_UP);
        send_action(ACT_DAY_DN);
        send_action(ACT_YEAR_UP);
        send_action(ACT_HOUR_UP);
        send_action(ACT_MIN_UP);
        send_action(ACT_SEC_UP);
        send_action(ACT_HOUR_DN);
        send_action(ACT_MIN_DN);
        send_action(ACT_SEC_DN);
        send_load(2100, 1, 31, 0, 0, 0);
        send_action(ACT_MONTH_UP);
        send_action(ACT_YEAR_UP);
        send_action(ACT_YEAR_DN);
        send_action(ACT_MONTH_DN);
        send_load(0, 0, 0, 0, 0, 0);
        send_action(ACT_MONTH_UP);
        send_action(ACT_YEAR_DN);
        send_load(4095, 15, 31, 31, 63, 63);
        send_action(ACT_DAY_DN);
        send_action(ACT_MONTH_UP);
        send_action(ACT_HOUR_UP);
        send_action(ACT_MIN_DN);
        send_action(ACT_SEC_UP);
        send_action(ACT_SPARE_A);
        send_action(ACT_SPARE_B);
    endtask

    initial begin
        int unsigned lo_years[NUM_PHASES];
        int unsigned hi_years[NUM_PHASES];
        int unsigned lo;
        int unsigned hi;
        lo_years = '{1970, 0, 2000, 0, 4095, 2100, 1999, 0, 0, 1970};
        hi_years = '{2100, 4095, 2000, 0, 4095, 1970, 2001, 0, 0, 2100};
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_checks();
        for (int p = 0; p < NUM_PHASES; p++) begin
            lo = lo_years[p];
            hi = hi_years[p];
            if (p == 7 || p == 8) begin
                lo = $urandom_range(0, 4095);
                hi = $urandom_range(lo, 4095);
            end
            // change bounds only with nothing in flight
            if (p != 0) begin
                wait_drain();
                write_bounds(YEAR_W'(lo), YEAR_W'(hi));
            end
            if (p == 1) begin
                send_load(0, 2, 28, 12, 30, 30);
                send_action(ACT_DAY_UP);
                send_action(ACT_DAY_UP);
            end
            random_traffic(REQS_PER_PHASE);
        end
        wait_drain();
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("Sent %0d requests and checked %0d results across %0d year-bound settings,",
                 sb.requests, sb.checked, NUM_PHASES);
        $display("covering loads, wraps, leap days, day clamps and spare codes; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
